// File: hdl/lpd_pkg.sv
// types, constants and helper functions shared by the percent decoder modules
`timescale 1ns / 1ps
package lpd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = 1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   // up to three output bytes caused by one input item, in order
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic            last;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic r;
      r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
          (c >= 8'h61 && c <= 8'h66);
      return r;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

// File: hdl/lpd_front.sv
// front end: escape state machine that turns each item into a burst of output bytes
`timescale 1ns / 1ps
module lpd_front import lpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output logic      push,
   output burst_type burst
);

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       hold_we;
   logic       b_hex;
   logic       fresh_emit;
   logic [7:0] b;
   logic       last;

   assign b          = req_data.in_byte;
   assign last       = req_data.in_last;
   assign b_hex      = is_hex(b);
   assign fresh_emit = !(b == PCT_CHAR && !last);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_PCT: begin
               if (b_hex) begin
                  phase_in = last ? PH_IDLE : PH_DIGIT;
               end else begin
                  phase_in = fresh_emit ? PH_IDLE : PH_PCT;
               end
            end
            PH_DIGIT: begin
               if (b_hex) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = fresh_emit ? PH_IDLE : PH_PCT;
               end
            end
            default: begin
               phase_in = fresh_emit ? PH_IDLE : PH_PCT;
            end
         endcase
      end
   end

   // burst contents
   always_comb begin
      burst       = '0;
      burst.last  = last;
      hold_we     = 1'b0;
      case (phase_ff)
         PH_PCT: begin
            burst.bytes[0] = PCT_CHAR;
            burst.bytes[1] = b;
            if (b_hex) begin
               burst.cnt = last ? 2'd2 : 2'd0;
               hold_we   = !last;
            end else begin
               burst.cnt = fresh_emit ? 2'd2 : 2'd1;
            end
         end
         PH_DIGIT: begin
            if (b_hex) begin
               burst.bytes[0] = {hex_value(held_ff), hex_value(b)};
               burst.cnt      = 2'd1;
            end else begin
               burst.bytes[0] = PCT_CHAR;
               burst.bytes[1] = held_ff;
               burst.bytes[2] = b;
               burst.cnt      = fresh_emit ? 2'd3 : 2'd2;
            end
         end
         default: begin
            burst.bytes[0] = b;
            burst.cnt      = fresh_emit ? 2'd1 : 2'd0;
         end
      endcase
   end

   assign push    = accept && (burst.cnt != 2'd0);
   assign held_in = (accept && hold_we) ? b : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// File: hdl/lpd_queue.sv
// two-entry burst queue between front and back
`timescale 1ns / 1ps
module lpd_queue import lpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  burst_type        wr_data,
   input  logic             pop,
   output burst_type        rd_data,
   output queue_status_type status
);

   burst_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/lpd_back.sv
// back end: serializes queued bursts into the output register one byte per cycle while the output is not stalled
`timescale 1ns / 1ps
module lpd_back import lpd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  burst_type        head,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load;
   logic       final_byte;

   assign load       = !valid_ff || !rsp_stall;
   assign final_byte = (idx_ff == head.cnt - 2'd1);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            data_in.out_byte = head.bytes[idx_ff];
            data_in.out_last = head.last && final_byte;
            if (final_byte) begin
               pop    = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hdl/lenient_percent_decoder_top.sv
// lenient percent decoder: escape front end, burst queue and output serializer
// an accepted item's burst is registered in the queue, then its first byte in the output register
// throughput: one item per cycle while each item yields at most one byte and the
// output is not stalled; the output register drains one byte per cycle, so broken
// escapes stall the input once the two-entry burst queue fills
// reset: synchronous; clears the escape phase, the queue and the output valid
`timescale 1ns / 1ps
module lenient_percent_decoder_top import lpd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             accept;
   logic             q_push;
   logic             q_pop;
   burst_type        burst;
   burst_type        head;
   queue_status_type q_status;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   lpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (q_push),
      .burst    (burst)
   );

   lpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (burst),
      .pop     (q_pop),
      .rd_data (head),
      .status  (q_status)
   );

   lpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("burst pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("burst popped from empty queue");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (burst.cnt != 2'd0))
      else $error("empty burst pushed");

   a_out_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

// File: sim/lenient_percent_decoder_top_test.sv
// self-checking testbench for the lenient percent decoder: directed and random text
`timescale 1ns / 1ps
module lenient_percent_decoder_top_test;
   import lpd_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam string HEX_CHARS = "0123456789ABCDEFabcdef";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   phase_type  esc_phase = PH_IDLE;
   logic [7:0] esc_digit = 8'h00;
   rsp_type    decoded_q[$];
   rsp_type    exp_rsp;
   logic [7:0] text_buf[$];

   int send_idle_pct = 8;
   int stall_pct = 85;
   int mismatches = 0;
   int items_sent = 0;
   int bytes_checked = 0;
   int idle_cycles = 0;

   lenient_percent_decoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic hex_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") begin
         v = c - "0";
      end else if (c >= "A" && c <= "F") begin
         v = c - "A" + 8'd10;
      end else if (c >= "a" && c <= "f") begin
         v = c - "a" + 8'd10;
      end
      return v[3:0];
   endfunction

   function void add_text(input logic [7:0] c);
      text_buf = {text_buf, c};
   endfunction

   function void push_decoded(input logic [7:0] b, input logic last);
      rsp_type r;
      r.out_byte = b;
      r.out_last = last;
      decoded_q = {decoded_q, r};
   endfunction

   function void take_plain(input logic [7:0] b, input logic last);
      if (b == PCT_CHAR && !last) begin
         esc_phase = PH_PCT;
      end else begin
         esc_phase = PH_IDLE;
         push_decoded(b, last);
      end
   endfunction

   function void predict_decoded(input logic [7:0] b, input logic last);
      case (esc_phase)
         PH_PCT: begin
            if (hex_char(b)) begin
               if (last) begin
                  esc_phase = PH_IDLE;
                  push_decoded(PCT_CHAR, 1'b0);
                  push_decoded(b, 1'b1);
               end else begin
                  esc_digit = b;
                  esc_phase = PH_DIGIT;
               end
            end else begin
               push_decoded(PCT_CHAR, 1'b0);
               take_plain(b, last);
            end
         end
         PH_DIGIT: begin
            if (hex_char(b)) begin
               esc_phase = PH_IDLE;
               push_decoded({nibble_of(esc_digit), nibble_of(b)}, last);
            end else begin
               push_decoded(PCT_CHAR, 1'b0);
               push_decoded(esc_digit, 1'b0);
               take_plain(b, last);
            end
         end
         default: begin
            take_plain(b, last);
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_hex();
      return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_non_hex();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (hex_char(c));
      return c;
   endfunction

   // one random piece of text: plain byte, good escape or broken escape
   function void add_token();
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            add_text(8'($urandom_range(255)));
         end
         4, 5, 6: begin
            add_text(PCT_CHAR);
            add_text(pick_hex());
            add_text(pick_hex());
         end
         7: begin
            add_text(PCT_CHAR);
            add_text(pick_non_hex());
         end
         8: begin
            add_text(PCT_CHAR);
            add_text(pick_hex());
            add_text(pick_non_hex());
         end
         default: begin
            add_text(PCT_CHAR);
         end
      endcase
   endfunction

   task automatic send_item(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.in_byte <= b;
      req_data.in_last <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_decoded(b, last);
      items_sent++;
   endtask

   // sends the buffered text as one string, last marker on its final byte
   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++) begin
         send_item(text_buf[i], i == text_buf.size() - 1);
      end
      text_buf.delete();
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_text(s[i]);
      end
      send_text();
   endtask

   task automatic test_plain_bytes();
      add_text(8'h00);
      add_text(8'hff);
      send_text();
   endtask

   task automatic test_valid_escapes();
      send_string("%41%fF");
   endtask

   task automatic test_broken_escapes();
      send_string("%g%4%2a");
      send_string("%%9z");
      send_string("%");
      send_string("%4");
      send_string("%4G");
   endtask

   task automatic test_random_text(input int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         repeat ($urandom_range(1, 5)) add_token();
         sent += text_buf.size();
         send_text();
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected item: byte %h last %b", rsp_data.out_byte,
                        rsp_data.out_last);
            end
         end else begin
            exp_rsp = decoded_q.pop_front();
            bytes_checked++;
            if (exp_rsp.out_byte !== rsp_data.out_byte ||
                exp_rsp.out_last !== rsp_data.out_last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected byte %h last %b, got byte %h last %b",
                           exp_rsp.out_byte, exp_rsp.out_last,
                           rsp_data.out_byte, rsp_data.out_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (req_valid || decoded_q.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_bytes();
      test_valid_escapes();
      test_broken_escapes();
      test_random_text(90);

      send_idle_pct = 85;
      stall_pct = 8;
      test_random_text(95);

      send_idle_pct = 0;
      stall_pct = 0;
      test_random_text(95);

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_q.size() != 0) begin
         mismatches++;
      end

      $display("sent %0d encoded bytes in strings of plain text, good and broken escapes",
               items_sent);
      $display("checked %0d decoded bytes under three stall patterns, %0d mismatches",
               bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: lenient_percent_decoder_top.f
hdl/lpd_pkg.sv
hdl/lpd_front.sv
hdl/lpd_queue.sv
hdl/lpd_back.sv
hdl/lenient_percent_decoder_top.sv
sim/lenient_percent_decoder_top_test.sv
